// ===== design/sps_pkg.sv =====
package sps_pkg;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_QUEUE     = 2'd1,
    OP_ACK       = 2'd2,
    OP_REPUBLISH = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_KEEPALIVE = 2'd0,
    KIND_DATA      = 2'd1,
    KIND_ACK       = 2'd2,
    KIND_REPUBLISH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_GOOD          = 2'd0,
    ST_SEQ_UNKNOWN   = 2'd1,
    ST_NOT_AVAILABLE = 2'd2
  } status_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_OLDEST = 3'd4;

  localparam logic [15:0] DEFAULT_KEEPALIVE = 16'd3;
  localparam logic [31:0] DEFAULT_INTERVAL  = 32'd1000;

  // broadcast to every pending cell
  typedef struct packed {
    logic        shift;
    logic        load;
    logic [15:0] tag;
  } pend_ctrl_t;

  // broadcast to every retained cell
  typedef struct packed {
    logic        capture;
    logic        shift_all;
    logic        shift_seen;
    logic        load;
    logic [31:0] cmp_seq;
    logic [31:0] load_seq;
    logic [15:0] load_tag;
  } ret_ctrl_t;

endpackage

// ===== design/sps_pend_cell.sv =====
module sps_pend_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  logic                 clk,
  input  sps_pkg::pend_ctrl_t  ctrl,
  input  logic [IDX_W-1:0]     load_idx,
  input  logic [15:0]          next_tag,
  output logic [15:0]          tag
);
  import sps_pkg::*;

  logic load_here;

  assign load_here = ctrl.load && (load_idx == IDX_W'(IDX));

  // shift towards the head, a load at this slot wins over the shift
  always_ff @(posedge clk) begin
    if (load_here) begin
      tag <= ctrl.tag;
    end else if (ctrl.shift) begin
      tag <= next_tag;
    end
  end

endmodule

// ===== design/sps_ret_cell.sv =====
module sps_ret_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  sps_pkg::ret_ctrl_t  ctrl,
  input  logic [IDX_W-1:0]    load_idx,
  input  logic [CNT_W-1:0]    fill,
  input  logic [31:0]         next_seq,
  input  logic [15:0]         next_tag,
  input  logic                seen_in,
  input  logic [31:0]         sel_seq_in,
  input  logic [15:0]         sel_tag_in,
  output logic [31:0]         seq,
  output logic [15:0]         tag,
  output logic                seen_out,
  output logic [31:0]         sel_seq_out,
  output logic [15:0]         sel_tag_out
);
  import sps_pkg::*;

  logic match_q;
  logic first;
  logic load_here;
  logic take_next;

  assign seen_out    = seen_in | match_q;
  assign first       = match_q & ~seen_in;
  assign sel_seq_out = sel_seq_in | (first ? seq : 32'd0);
  assign sel_tag_out = sel_tag_in | (first ? tag : 16'd0);

  assign load_here = ctrl.load && (load_idx == IDX_W'(IDX));
  assign take_next = ctrl.shift_all || (ctrl.shift_seen && seen_out);

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match_q <= (fill > CNT_W'(IDX)) && (seq == ctrl.cmp_seq);
    end
    if (load_here) begin
      seq <= ctrl.load_seq;
      tag <= ctrl.load_tag;
    end else if (take_next) begin
      seq <= next_seq;
      tag <= next_tag;
    end
  end

endmodule

// ===== design/subscription_publish_scheduler.sv =====
// Publish timing, pending notification queue and retransmit store of one
// subscription.
// Items: raise start with opcode and its fields while busy is low; the item
// is taken at that edge. A tick (now_ms) may give a data publish or a
// keep-alive, a queue item (note_tag) gives nothing, acknowledge and
// republish (seq_number) always give one result.
// Each item goes through capture, evaluate (per-cell sequence compare,
// elapsed-time subtract and the interval times keep-alive multiply, all
// registered) and commit. busy is high in the evaluate and commit states,
// so a new item is taken only once the last one has been committed.
// A result appears on kind, status, out_seq, out_tag, more_pending and
// retained_count with done high for exactly one cycle, the cycle after
// commit; the receiver cannot stall it.
// Config: cfg_we, cfg_index, cfg_data write a register; the user writes
// only while idle (unenforced). Indexes past the last register are ignored.
// Reset (rst, synchronous) restores the register defaults, empties the
// pending queue and retransmit store and restarts sequence numbers at 1.
module subscription_publish_scheduler #(
  parameter int PENDING_DEPTH = 64,
  parameter int RETAIN_DEPTH  = 16,
  localparam int RCNT_W = $clog2(RETAIN_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode,
  input  logic [47:0]                  now_ms,
  input  logic [31:0]                  seq_number,
  input  logic [15:0]                  note_tag,
  output logic                         done,
  output logic [1:0]                   kind,
  output logic [1:0]                   status,
  output logic [31:0]                  out_seq,
  output logic [15:0]                  out_tag,
  output logic                         more_pending,
  output logic [RCNT_W-1:0]            retained_count,
  input  logic                         cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sps_pkg::*;

  localparam int PIDX_W = $clog2(PENDING_DEPTH);
  localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int RIDX_W = (RETAIN_DEPTH > 1) ? $clog2(RETAIN_DEPTH) : 1;
  localparam int LIM_W  = (PCNT_W > 7) ? PCNT_W : 7;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EVAL   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state;

  // configuration
  logic [31:0] publish_interval_ms;
  logic [15:0] keepalive_count;
  logic        publish_enable;
  logic [6:0]  pending_limit;
  logic        drop_oldest;

  // captured item
  opcode_t     op_q;
  logic [47:0] now_q;
  logic [31:0] seq_q;
  logic [15:0] tag_q;

  // subscription state
  logic [47:0]       last_publish, last_publish_next;
  logic              last_valid, last_valid_next;
  logic              first_sent, first_sent_next;
  logic [31:0]       next_seq, next_seq_next;
  logic [PCNT_W-1:0] pend_count, pend_count_next;
  logic [RCNT_W-1:0] ret_fill, ret_fill_next;

  // evaluate stage results
  logic [48:0] diff;
  logic [47:0] ka_span;

  logic [31:0] interval_eff;
  logic [47:0] ka_prod;

  // output next values
  logic        emit;
  kind_t       kind_next;
  status_t     status_next;
  logic [31:0] out_seq_next;
  logic [15:0] out_tag_next;
  logic        more_next;

  // cell chains
  pend_ctrl_t        pc;
  logic [PIDX_W-1:0] pend_load_idx;
  logic [15:0]       pend_tag [PENDING_DEPTH];

  ret_ctrl_t         rc;
  logic [RIDX_W-1:0] ret_load_idx;
  logic [31:0]       ret_seq [RETAIN_DEPTH];
  logic [15:0]       ret_tag [RETAIN_DEPTH];
  logic              seen [RETAIN_DEPTH+1];
  logic [31:0]       sel_seq [RETAIN_DEPTH+1];
  logic [15:0]       sel_tag [RETAIN_DEPTH+1];

  logic              found;
  logic              has_data;
  logic [47:0]       span;
  logic              ready;
  logic [LIM_W-1:0]  lim7;
  logic [LIM_W-1:0]  lim;
  logic              overflow;

  assign busy = (state != S_IDLE);

  assign interval_eff = (publish_interval_ms == 32'd0) ? 32'd1 : publish_interval_ms;
  assign ka_prod      = 48'(interval_eff) * 48'(keepalive_count);

  assign found    = seen[RETAIN_DEPTH];
  assign has_data = publish_enable && (pend_count != '0);
  assign span     = (!first_sent || has_data) ? {16'd0, interval_eff} : ka_span;
  assign ready    = !diff[48] && (diff[47:0] >= span);

  assign lim7     = (pending_limit == 7'd0) ? LIM_W'(1) : LIM_W'(pending_limit);
  assign lim      = (lim7 > LIM_W'(PENDING_DEPTH)) ? LIM_W'(PENDING_DEPTH) : lim7;
  assign overflow = LIM_W'(pend_count) >= lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (start) state <= S_EVAL;
        S_EVAL:   state <= S_COMMIT;
        S_COMMIT: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      publish_interval_ms <= DEFAULT_INTERVAL;
      keepalive_count     <= DEFAULT_KEEPALIVE;
      publish_enable      <= 1'b1;
      pending_limit       <= 7'd1;
      drop_oldest         <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERVAL:    publish_interval_ms <= cfg_data[31:0];
        REG_KEEPALIVE:   keepalive_count <= (cfg_data[15:0] == 16'd0) ?
                                            DEFAULT_KEEPALIVE : cfg_data[15:0];
        REG_ENABLE:      publish_enable <= cfg_data[0];
        REG_LIMIT:       pending_limit <= cfg_data[6:0];
        REG_DROP_OLDEST: drop_oldest <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q  <= opcode_t'(opcode);
      now_q <= now_ms;
      seq_q <= seq_number;
      tag_q <= note_tag;
    end
    if (state == S_EVAL) begin
      diff    <= {1'b0, now_q} - {1'b0, last_publish};
      ka_span <= ka_prod;
    end
  end

  // commit decisions
  always_comb begin
    last_publish_next = last_publish;
    last_valid_next   = last_valid;
    first_sent_next   = first_sent;
    next_seq_next     = next_seq;
    pend_count_next   = pend_count;
    ret_fill_next     = ret_fill;
    pc.tag            = tag_q;
    pc.shift          = 1'b0;
    pc.load           = 1'b0;
    pend_load_idx     = pend_count[PIDX_W-1:0];
    rc.capture        = (state == S_EVAL);
    rc.cmp_seq        = seq_q;
    rc.load_seq       = next_seq;
    rc.load_tag       = pend_tag[0];
    rc.shift_all      = 1'b0;
    rc.shift_seen     = 1'b0;
    rc.load           = 1'b0;
    ret_load_idx      = ret_fill[RIDX_W-1:0];
    emit              = 1'b0;
    kind_next         = KIND_KEEPALIVE;
    status_next       = ST_GOOD;
    out_seq_next      = seq_q;
    out_tag_next      = 16'd0;
    more_next         = 1'b0;
    if (state == S_COMMIT) begin
      unique case (op_q)
        OP_QUEUE: begin
          if (!overflow) begin
            pc.load         = 1'b1;
            pend_count_next = pend_count + PCNT_W'(1);
          end else if (drop_oldest && pend_count != '0) begin
            pc.shift      = 1'b1;
            pc.load       = 1'b1;
            pend_load_idx = PIDX_W'(pend_count - PCNT_W'(1));
          end
        end
        OP_ACK: begin
          emit      = 1'b1;
          kind_next = KIND_ACK;
          if (found) begin
            rc.shift_seen = 1'b1;
            ret_fill_next = ret_fill - RCNT_W'(1);
          end else begin
            status_next = ST_SEQ_UNKNOWN;
          end
        end
        OP_REPUBLISH: begin
          emit      = 1'b1;
          kind_next = KIND_REPUBLISH;
          if (found) begin
            out_seq_next = sel_seq[RETAIN_DEPTH];
            out_tag_next = sel_tag[RETAIN_DEPTH];
          end else begin
            status_next = ST_NOT_AVAILABLE;
          end
        end
        OP_TICK: begin
          if (!last_valid) begin
            // a tick before the timer is primed only primes it, if publishing is on
            if (publish_enable) begin
              last_publish_next = now_q;
              last_valid_next   = 1'b1;
            end
          end else if (ready) begin
            emit              = 1'b1;
            last_publish_next = now_q;
            first_sent_next   = 1'b1;
            out_seq_next      = next_seq;
            if (has_data) begin
              kind_next       = KIND_DATA;
              out_tag_next    = pend_tag[0];
              more_next       = (pend_count != PCNT_W'(1));
              pc.shift        = 1'b1;
              pend_count_next = pend_count - PCNT_W'(1);
              next_seq_next   = (next_seq == '1) ? 32'd1 : next_seq + 32'd1;
              rc.load         = 1'b1;
              if (ret_fill == RCNT_W'(RETAIN_DEPTH)) begin
                rc.shift_all = 1'b1;
                ret_load_idx = RIDX_W'(RETAIN_DEPTH - 1);
              end else begin
                ret_fill_next = ret_fill + RCNT_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_publish <= '0;
      last_valid   <= 1'b0;
      first_sent   <= 1'b0;
      next_seq     <= 32'd1;
      pend_count   <= '0;
      ret_fill     <= '0;
      done         <= 1'b0;
    end else begin
      last_publish <= last_publish_next;
      last_valid   <= last_valid_next;
      first_sent   <= first_sent_next;
      next_seq     <= next_seq_next;
      pend_count   <= pend_count_next;
      ret_fill     <= ret_fill_next;
      done         <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind           <= kind_next;
      status         <= status_next;
      out_seq        <= out_seq_next;
      out_tag        <= out_tag_next;
      more_pending   <= more_next;
      retained_count <= ret_fill_next;
    end
  end

  // pending queue, head in cell 0
  for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_pend
    logic [15:0] nxt;
    if (i == PENDING_DEPTH - 1) begin : g_last
      assign nxt = 16'd0;
    end else begin : g_mid
      assign nxt = pend_tag[i+1];
    end
    sps_pend_cell #(
      .IDX   (i),
      .IDX_W (PIDX_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (pc),
      .load_idx (pend_load_idx),
      .next_tag (nxt),
      .tag      (pend_tag[i])
    );
  end

  // retransmit store, oldest in cell 0; match flags ripple towards the end
  assign seen[0]    = 1'b0;
  assign sel_seq[0] = 32'd0;
  assign sel_tag[0] = 16'd0;

  for (genvar i = 0; i < RETAIN_DEPTH; i++) begin : g_ret
    logic [31:0] nseq;
    logic [15:0] ntag;
    if (i == RETAIN_DEPTH - 1) begin : g_last
      assign nseq = 32'd0;
      assign ntag = 16'd0;
    end else begin : g_mid
      assign nseq = ret_seq[i+1];
      assign ntag = ret_tag[i+1];
    end
    sps_ret_cell #(
      .IDX   (i),
      .IDX_W (RIDX_W),
      .CNT_W (RCNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (rc),
      .load_idx    (ret_load_idx),
      .fill        (ret_fill),
      .next_seq    (nseq),
      .next_tag    (ntag),
      .seen_in     (seen[i]),
      .sel_seq_in  (sel_seq[i]),
      .sel_tag_in  (sel_tag[i]),
      .seq         (ret_seq[i]),
      .tag         (ret_tag[i]),
      .seen_out    (seen[i+1]),
      .sel_seq_out (sel_seq[i+1]),
      .sel_tag_out (sel_tag[i+1])
    );
  end

endmodule

// ===== sim/tb_subscription_publish_scheduler.sv =====
module tb_subscription_publish_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam int PEND_DEPTH = 64;
  localparam int RET_DEPTH  = 16;
  localparam int RCNT_W     = $clog2(RET_DEPTH + 1);
  localparam int SETTLE     = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    kind_t              kind;
    status_t            status;
    logic [31:0]        seq;
    logic [15:0]        tag;
    logic               more;
    logic [RCNT_W-1:0]  held;
  } publish_msg_t;

  // mirror of the subscription state, plus the messages still owed by the block
  class publish_mirror;
    logic [31:0] period_ms;
    logic [15:0] keepalive;
    logic        enable;
    logic [6:0]  limit;
    logic        drop_oldest;
    logic [47:0] last_publish;
    logic        last_valid;
    logic        first_sent;
    logic [31:0] next_seq;
    logic [15:0] pending_tags[$];
    logic [31:0] kept_seq[$];
    logic [15:0] kept_tag[$];
    publish_msg_t awaited[$];
    int unsigned fails;
    int unsigned kind_seen[4];

    function new();
      period_ms    = DEFAULT_INTERVAL;
      keepalive    = DEFAULT_KEEPALIVE;
      enable       = 1'b1;
      limit        = 7'd1;
      drop_oldest  = 1'b1;
      last_publish = '0;
      last_valid   = 1'b0;
      first_sent   = 1'b0;
      next_seq     = 32'd1;
      fails        = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_INTERVAL:    period_ms = data;
        REG_KEEPALIVE:   keepalive = (data[15:0] == 16'd0) ? DEFAULT_KEEPALIVE : data[15:0];
        REG_ENABLE:      enable = data[0];
        REG_LIMIT:       limit = data[6:0];
        REG_DROP_OLDEST: drop_oldest = data[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] interval_eff();
      return (period_ms == 32'd0) ? 64'd1 : {32'd0, period_ms};
    endfunction

    function bit elapsed(logic [47:0] now, logic [63:0] span);
      if (now < last_publish) return 1'b0;
      return {16'd0, now - last_publish} >= span;
    endfunction

    function bit due(logic [47:0] now);
      if (!last_valid) return 1'b0;
      if (!first_sent || (enable && pending_tags.size() > 0))
        return elapsed(now, interval_eff());
      return elapsed(now, interval_eff() * {48'd0, keepalive});
    endfunction

    function int find_kept(logic [31:0] seq);
      foreach (kept_seq[i])
        if (kept_seq[i] == seq) return i;
      return -1;
    endfunction

    function publish_msg_t make_msg(kind_t k, status_t s, logic [31:0] q, logic [15:0] t,
                                    logic m);
      publish_msg_t r;
      r.kind   = k;
      r.status = s;
      r.seq    = q;
      r.tag    = t;
      r.more   = m;
      r.held   = RCNT_W'(kept_seq.size());
      return r;
    endfunction

    function void owe(publish_msg_t m);
      awaited.insert(awaited.size(), m);
    endfunction

    function void take_item(opcode_t op, logic [47:0] now, logic [31:0] seq,
                            logic [15:0] tag);
      int          pos;
      int unsigned lim;
      logic [15:0] head;
      logic [31:0] issued;
      case (op)
        OP_QUEUE: begin
          lim = (limit == 7'd0) ? 1 : limit;
          if (lim > PEND_DEPTH) lim = PEND_DEPTH;
          // over the limit: either shift out the oldest or lose the new tag
          if (pending_tags.size() + 1 > lim) begin
            if (drop_oldest && pending_tags.size() > 0) begin
              pending_tags.delete(0);
              pending_tags.insert(pending_tags.size(), tag);
            end
          end else begin
            pending_tags.insert(pending_tags.size(), tag);
          end
        end
        OP_ACK: begin
          pos = find_kept(seq);
          if (pos < 0) begin
            owe(make_msg(KIND_ACK, ST_SEQ_UNKNOWN, seq, 16'd0, 1'b0));
          end else begin
            kept_seq.delete(pos);
            kept_tag.delete(pos);
            owe(make_msg(KIND_ACK, ST_GOOD, seq, 16'd0, 1'b0));
          end
        end
        OP_REPUBLISH: begin
          pos = find_kept(seq);
          if (pos < 0)
            owe(make_msg(KIND_REPUBLISH, ST_NOT_AVAILABLE, seq, 16'd0, 1'b0));
          else
            owe(make_msg(KIND_REPUBLISH, ST_GOOD, kept_seq[pos], kept_tag[pos], 1'b0));
        end
        default: begin
          // first tick with publishing on starts the clock
          if (enable && !last_valid) begin
            last_publish = now;
            last_valid   = 1'b1;
          end
          if (due(now)) begin
            last_publish = now;
            first_sent   = 1'b1;
            if (!(enable && pending_tags.size() > 0)) begin
              owe(make_msg(KIND_KEEPALIVE, ST_GOOD, next_seq, 16'd0, 1'b0));
            end else begin
              head     = pending_tags[0];
              pending_tags.delete(0);
              issued   = next_seq;
              next_seq = (next_seq == 32'hFFFF_FFFF) ? 32'd1 : next_seq + 32'd1;
              if (kept_seq.size() >= RET_DEPTH) begin
                kept_seq.delete(0);
                kept_tag.delete(0);
              end
              kept_seq.insert(kept_seq.size(), issued);
              kept_tag.insert(kept_tag.size(), head);
              owe(make_msg(KIND_DATA, ST_GOOD, issued, head, pending_tags.size() > 0));
            end
          end
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        fails++;
      end
    endfunction

    function void match_result(logic [1:0] k, logic [1:0] s, logic [31:0] q, logic [15:0] t,
                               logic m, logic [RCNT_W-1:0] h);
      publish_msg_t e;
      if (awaited.size() == 0) begin
        $error("result with none outstanding: kind %0d seq %0d", k, q);
        fails++;
        return;
      end
      e = awaited[0];
      awaited.delete(0);
      kind_seen[e.kind]++;
      check_field("kind", 32'(e.kind), 32'(k));
      check_field("status", 32'(e.status), 32'(s));
      check_field("out_seq", e.seq, q);
      check_field("out_tag", 32'(e.tag), 32'(t));
      check_field("more_pending", 32'(e.more), 32'(m));
      check_field("retained_count", 32'(e.held), 32'(h));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            opcode = OP_TICK;
  logic [47:0]           now_ms = '0;
  logic [31:0]           seq_number = '0;
  logic [15:0]           note_tag = '0;
  logic                  done;
  logic [1:0]            kind;
  logic [1:0]            status;
  logic [31:0]           out_seq;
  logic [15:0]           out_tag;
  logic                  more_pending;
  logic [RCNT_W-1:0]     retained_count;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  publish_mirror mirror;
  logic [47:0]   now_cursor = '0;
  bit            quiet = 1'b0;
  int unsigned   op_count[4] = '{0, 0, 0, 0};
  int unsigned   settings = 0;

  subscription_publish_scheduler #(
    .PENDING_DEPTH(PEND_DEPTH),
    .RETAIN_DEPTH (RET_DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .now_ms        (now_ms),
    .seq_number    (seq_number),
    .note_tag      (note_tag),
    .done          (done),
    .kind          (kind),
    .status        (status),
    .out_seq       (out_seq),
    .out_tag       (out_tag),
    .more_pending  (more_pending),
    .retained_count(retained_count),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // outputs are registered, so mid-cycle sampling sees what the next edge transfers
  always @(negedge clk) begin
    if (!rst && done)
      mirror.match_result(kind, status, out_seq, out_tag, more_pending, retained_count);
  end

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 24) == 0) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [15:0] rand_tag();
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic pause(input int n);
    if (n > 0) begin
      start      <= 1'b0;
      seq_number <= $urandom;
      note_tag   <= rand_tag();
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(input opcode_t op, input logic [47:0] t_now, input logic [31:0] seq,
                           input logic [15:0] tag);
    start      <= 1'b1;
    opcode     <= op;
    now_ms     <= t_now;
    seq_number <= seq;
    note_tag   <= tag;
    do @(posedge clk); while (busy);
    mirror.take_item(op, t_now, seq, tag);
    op_count[op]++;
    pause(pick_gap());
  endtask

  // hold off until every owed result has been transferred and the block is quiet
  task automatic drain();
    start <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    mirror.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_seq();
    if (mirror.kept_seq.size() > 0 && $urandom_range(0, 9) < 7)
      return mirror.kept_seq[$urandom_range(0, mirror.kept_seq.size() - 1)];
    if ($urandom_range(0, 1) == 0)
      return mirror.next_seq - $urandom_range(0, 20);
    return $urandom;
  endfunction

  task automatic random_item(input logic [63:0] step_max);
    int          r;
    logic [63:0] wide;
    logic [47:0] t;
    r    = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    t    = wide[47:0];
    if (r < 35) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        now_cursor = wide[47:0];
        t = now_cursor;
      end else if (r < 9) begin
        // time running backwards must never count as elapsed
        t = now_cursor - 48'(wide % (step_max + 1));
      end else begin
        now_cursor = now_cursor + 48'(wide % (step_max + 1));
        t = now_cursor;
      end
      send_item(OP_TICK, t, $urandom, rand_tag());
    end else if (r < 70) begin
      send_item(OP_QUEUE, t, $urandom, rand_tag());
    end else if (r < 85) begin
      send_item(OP_ACK, t, pick_seq(), rand_tag());
    end else begin
      send_item(OP_REPUBLISH, t, pick_seq(), rand_tag());
    end
  endtask

  task automatic run_phase(input logic [31:0] interval, input logic [15:0] ka, input logic en,
                           input logic [6:0] lim, input logic drop, input logic [63:0] step_max,
                           input int n);
    drain();
    write_cfg(REG_INTERVAL, interval);
    write_cfg(REG_KEEPALIVE, {16'd0, ka});
    write_cfg(REG_ENABLE, {31'd0, en});
    write_cfg(REG_LIMIT, {25'd0, lim});
    write_cfg(REG_DROP_OLDEST, {31'd0, drop});
    settings++;
    repeat (n) begin
      random_item(step_max);
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    mirror = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // publishing off before the first tick: nothing primes
    write_cfg(REG_ENABLE, 32'd0);
    settings++;
    send_item(OP_TICK, 48'd5, $urandom, rand_tag());
    send_item(OP_QUEUE, 48'($urandom), $urandom, 16'hFFFF);
    send_item(OP_TICK, 48'hFFFF_FFFF_FFFF, $urandom, rand_tag());
    drain();
    write_cfg(REG_ENABLE, 32'd1);
    write_cfg(REG_UNUSED, '1);
    settings++;
    send_item(OP_TICK, 48'd0, $urandom, rand_tag());
    send_item(OP_QUEUE, 48'($urandom), $urandom, 16'h0000);
    send_item(OP_TICK, 48'd999, $urandom, rand_tag());
    send_item(OP_TICK, 48'd1000, $urandom, rand_tag());
    send_item(OP_TICK, 48'd500, $urandom, rand_tag());
    send_item(OP_TICK, 48'd3999, $urandom, rand_tag());
    send_item(OP_TICK, 48'd4000, $urandom, rand_tag());
    send_item(OP_REPUBLISH, 48'($urandom), 32'd1, rand_tag());
    send_item(OP_ACK, 48'($urandom), 32'd1, rand_tag());
    send_item(OP_ACK, 48'($urandom), 32'd1, rand_tag());
    send_item(OP_REPUBLISH, 48'($urandom), 32'd1, rand_tag());
    send_item(OP_ACK, 48'($urandom), 32'd0, rand_tag());
    send_item(OP_REPUBLISH, 48'($urandom), 32'hFFFF_FFFF, rand_tag());
    drain();
    // drop newest on overflow, zero interval acts as one
    write_cfg(REG_LIMIT, 32'd2);
    write_cfg(REG_DROP_OLDEST, 32'd0);
    write_cfg(REG_INTERVAL, 32'd0);
    settings++;
    send_item(OP_QUEUE, 48'($urandom), $urandom, 16'hA5A5);
    send_item(OP_QUEUE, 48'($urandom), $urandom, 16'h5A5A);
    send_item(OP_QUEUE, 48'($urandom), $urandom, 16'hFFFF);
    send_item(OP_TICK, 48'd4000, $urandom, rand_tag());
    send_item(OP_TICK, 48'd4001, $urandom, rand_tag());
    send_item(OP_TICK, 48'd4002, $urandom, rand_tag());
    send_item(OP_TICK, 48'hFFFF_FFFF_FFFF, $urandom, rand_tag());
    send_item(OP_ACK, 48'($urandom), 32'hFFFF_FFFF, rand_tag());
    send_item(OP_TICK, 48'd0, $urandom, rand_tag());
    now_cursor = 48'd5000;

    run_phase(32'd1, 16'd0, 1'b1, 7'd64, 1'b1, 64'd3, 90);
    run_phase(32'd0, 16'd1, 1'b1, 7'd0, 1'b0, 64'd2, 70);
    run_phase(32'd7, 16'hFFFF, 1'b1, 7'd5, 1'b1, 64'd20, 60);
    run_phase(32'd5, 16'd2, 1'b0, 7'd127, 1'b1, 64'd15, 50);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 7'd3, 1'b0, 64'hFFFF_FFFF_FFFF, 40);
    run_phase(32'd3, 16'd4, 1'b1, 7'd16, 1'b1, 64'd12, 110);
    drain();

    $display("stimulus: %0d ticks, %0d queued tags, %0d acks, %0d republishes, %0d settings",
             op_count[OP_TICK], op_count[OP_QUEUE], op_count[OP_ACK],
             op_count[OP_REPUBLISH], settings);
    $display("results: %0d data, %0d keep-alive, %0d ack, %0d republish",
             mirror.kind_seen[KIND_DATA], mirror.kind_seen[KIND_KEEPALIVE],
             mirror.kind_seen[KIND_ACK], mirror.kind_seen[KIND_REPUBLISH]);
    if (mirror.fails == 0 && mirror.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
